[sv/isadma_pkg.sv]
// Shared types, codes and helpers of the ISA DMA controller register block.
// No dependencies; compiled first, ahead of the interfaces and the core.
`default_nettype none

package isadma_pkg;

    localparam int CHANNEL_COUNT = 4;
    localparam int CH_W          = 2;

    // Bus access and device event codes
    typedef enum logic [3:0] {
        ACT_CHAN_RD     = 4'd0,
        ACT_CHAN_WR     = 4'd1,
        ACT_CTL_RD      = 4'd2,
        ACT_CTL_WR      = 4'd3,
        ACT_PAGE_RD     = 4'd4,
        ACT_PAGE_WR     = 4'd5,
        ACT_HPAGE_RD    = 4'd6,
        ACT_HPAGE_WR    = 4'd7,
        ACT_DREQ_HOLD   = 4'd8,
        ACT_DREQ_REL    = 4'd9,
        ACT_PROGRESS    = 4'd10,
        ACT_ADDR_QUERY  = 4'd11
    } action_t;

    // Control region ports
    typedef enum logic [2:0] {
        CTL_COMMAND     = 3'd0,
        CTL_REQUEST     = 3'd1,
        CTL_SINGLE_MASK = 3'd2,
        CTL_MODE        = 3'd3,
        CTL_CLEAR_FF    = 3'd4,
        CTL_MASTER_RST  = 3'd5,
        CTL_MASK_CLEAR  = 3'd6,
        CTL_MASK_WRITE  = 3'd7
    } ctl_port_t;

    // Control read ports
    localparam logic [2:0] CTL_RD_STATUS = 3'd0;
    localparam logic [2:0] CTL_RD_MASK   = 3'd1;

    // Command bits the block does not support (only bit 2 is accepted)
    localparam logic [7:0] CMD_UNSUPPORTED = 8'hfb;

    // Mode register fields
    localparam int MODE_AUTOINIT_BIT = 4;
    localparam int MODE_DOWN_BIT     = 5;

    typedef struct packed {
        logic            hit;
        logic [CH_W-1:0] chan;
    } page_map_t;

    // Map a page port to its channel; ports 0, 4, 5 and 6 have none
    function automatic page_map_t page_chan(input logic [2:0] port);
        page_map_t m;
        m.hit  = 1'b1;
        m.chan = '0;
        case (port)
            3'd1:    m.chan = 2'd2;
            3'd2:    m.chan = 2'd3;
            3'd3:    m.chan = 2'd1;
            3'd7:    m.chan = 2'd0;
            default: m.hit  = 1'b0;
        endcase
        return m;
    endfunction

    // Shift a 16-bit value left by the word shift into 17 bits
    function automatic logic [16:0] word_scale(input logic [15:0] v, input logic sh);
        return sh ? {v, 1'b0} : {1'b0, v};
    endfunction

endpackage

`default_nettype wire

[sv/isadma_in_if.sv]
// Request channel of the ISA DMA controller: valid/ready plus one bus access
// or device event. Depends on nothing.
`default_nettype none

interface isadma_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [2:0]  port;
    logic [7:0]  write_data;
    logic [1:0]  channel;
    logic [17:0] position;
    logic [17:0] length;

    modport source (
        output valid, action, port, write_data, channel, position, length,
        input  ready
    );

    modport sink (
        input  valid, action, port, write_data, channel, position, length,
        output ready
    );
endinterface

`default_nettype wire

[sv/isadma_out_if.sv]
// Result channel of the ISA DMA controller: valid/ready plus one result.
// Depends on nothing.
`default_nettype none

interface isadma_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [3:0]  active_channels;
    logic [3:0]  terminal_count;
    logic        command_rejected;
    logic [31:0] mem_address;
    logic        verify_only;
    logic        autoinit;
    logic [17:0] transfer_length;

    modport source (
        output valid, read_data, active_channels, terminal_count, command_rejected,
               mem_address, verify_only, autoinit, transfer_length,
        input  ready
    );

    modport sink (
        input  valid, read_data, active_channels, terminal_count, command_rejected,
               mem_address, verify_only, autoinit, transfer_length,
        output ready
    );
endinterface

`default_nettype wire

[sv/isa_dma_controller_registers_core.sv]
// Top level of the four-channel ISA DMA controller register block.
// Depends on isadma_pkg, isadma_in_if and isadma_out_if.
//
// Usage:
//   req_chan carries one request per handshake: a channel, control or page
//   register access, or a device event (DREQ hold/release, transfer
//   progress, memory-address query). rsp_chan returns exactly one result
//   per request, in order.
//   cfg_write_en/cfg_write_data set word_shift (0 byte, 1 word controller);
//   write it only while no request is in flight.
//   The register file is updated at the accepting edge and the result lands
//   in the output register on that same edge.
//   Throughput is one request per cycle while rsp_chan.ready holds, set by
//   the register update path feeding the output register.
//   When the receiver stalls, the held result stays put and req_chan.ready
//   drops until it is taken; ready follows rsp_chan.ready combinationally.
//   Reset clears all channel, page, command and status registers, sets the
//   mask to all ones, clears the byte flip-flop and word_shift, and leaves
//   the result register empty.
`default_nettype none

module isa_dma_controller_registers_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic        cfg_write_data,
    isadma_in_if.sink        req_chan,
    isadma_out_if.source     rsp_chan
);
    import isadma_pkg::*;

    // Register file
    logic [15:0] base_address_reg    [CHANNEL_COUNT];
    logic [15:0] base_count_reg      [CHANNEL_COUNT];
    logic [16:0] current_address_reg [CHANNEL_COUNT];
    logic [17:0] current_count_reg   [CHANNEL_COUNT];
    logic [7:0]  channel_mode_reg    [CHANNEL_COUNT];
    logic [7:0]  page_low_reg        [CHANNEL_COUNT];
    logic [7:0]  page_high_reg       [CHANNEL_COUNT];
    logic [7:0]  command_reg;
    logic [7:0]  mask_reg;
    logic [7:0]  status_reg;
    logic        byte_ff_reg;
    logic        word_shift_reg;

    logic [15:0] base_address_next;
    logic [15:0] base_count_next;
    logic [16:0] current_address_next;
    logic [17:0] current_count_next;
    logic [7:0]  channel_mode_next;
    logic [7:0]  page_low_next;
    logic [7:0]  page_high_next;
    logic [7:0]  command_next;
    logic [7:0]  mask_next;
    logic [7:0]  status_next;
    logic        byte_ff_next;

    // Result register
    logic        out_valid_reg;
    logic [7:0]  read_data_reg;
    logic [3:0]  active_reg;
    logic [3:0]  tc_reg;
    logic        rejected_reg;
    logic [31:0] mem_address_reg;
    logic        verify_reg;
    logic        autoinit_reg;
    logic [17:0] tlen_reg;

    logic [7:0]  read_data_next;
    logic        rejected_next;
    logic [31:0] mem_address_next;
    logic        verify_next;
    logic        autoinit_next;
    logic [17:0] tlen_next;

    logic            accept;
    logic [CH_W-1:0] idx;
    page_map_t       pmap;
    logic [16:0]     chan_value;
    logic [16:0]     cc_low;
    logic [16:0]     ba_scaled;
    logic [16:0]     count_plus;
    logic [17:0]     full_len;
    logic [31:0]     phys;
    logic [15:0]     ba_new;
    logic [7:0]      mode_sel;

    assign accept         = req_chan.valid && req_chan.ready;
    assign req_chan.ready = !out_valid_reg || rsp_chan.ready;
    assign pmap           = page_chan(req_chan.port);

    // Pick the one channel this request touches
    always_comb
    begin
        case (req_chan.action)
            ACT_CHAN_RD, ACT_CHAN_WR:                        idx = req_chan.port[2:1];
            ACT_CTL_WR:                                      idx = req_chan.write_data[1:0];
            ACT_PAGE_RD, ACT_PAGE_WR, ACT_HPAGE_RD, ACT_HPAGE_WR: idx = pmap.chan;
            default:                                         idx = req_chan.channel;
        endcase
    end

    // Derived values of the selected channel
    assign mode_sel   = channel_mode_reg[idx];
    assign cc_low     = current_count_reg[idx][16:0];
    assign ba_scaled  = word_scale(base_count_reg[idx], word_shift_reg);
    assign count_plus = {1'b0, base_count_reg[idx]} + 17'd1;
    assign full_len   = word_shift_reg ? {count_plus, 1'b0} : {1'b0, count_plus};
    assign phys       = {1'b0, page_high_reg[idx][6:0], page_low_reg[idx], 16'h0000}
                      | {15'd0, current_address_reg[idx]};

    // Channel read value; only bits 16..0 can reach the returned byte
    always_comb
    begin
        if (req_chan.port[0])
        begin
            chan_value = ba_scaled - cc_low;
        end
        else if (mode_sel[MODE_DOWN_BIT])
        begin
            chan_value = current_address_reg[idx] - cc_low;
        end
        else
        begin
            chan_value = current_address_reg[idx] + cc_low;
        end
    end

    assign ba_new = req_chan.port[0] ? base_address_reg[idx]
                                     : {req_chan.write_data, base_address_reg[idx][7:0]};

    // Register update and result for one request
    always_comb
    begin
        base_address_next    = base_address_reg[idx];
        base_count_next      = base_count_reg[idx];
        current_address_next = current_address_reg[idx];
        current_count_next   = current_count_reg[idx];
        channel_mode_next    = channel_mode_reg[idx];
        page_low_next        = page_low_reg[idx];
        page_high_next       = page_high_reg[idx];
        command_next         = command_reg;
        mask_next            = mask_reg;
        status_next          = status_reg;
        byte_ff_next         = byte_ff_reg;
        read_data_next       = 8'h00;
        rejected_next        = 1'b0;
        mem_address_next     = 32'h0000_0000;
        verify_next          = 1'b0;
        autoinit_next        = 1'b0;
        tlen_next            = 18'd0;

        case (req_chan.action)
            ACT_CHAN_RD:
            begin
                byte_ff_next = !byte_ff_reg;
                case ({word_shift_reg, byte_ff_reg})
                    2'b00:   read_data_next = chan_value[7:0];
                    2'b01:   read_data_next = chan_value[15:8];
                    2'b10:   read_data_next = chan_value[8:1];
                    default: read_data_next = chan_value[16:9];
                endcase
            end
            ACT_CHAN_WR:
            begin
                byte_ff_next = !byte_ff_reg;
                if (byte_ff_reg)
                begin
                    // High byte: reload current address, clear current count
                    if (req_chan.port[0])
                    begin
                        base_count_next = {req_chan.write_data, base_count_reg[idx][7:0]};
                    end
                    else
                    begin
                        base_address_next = ba_new;
                    end
                    current_address_next = word_scale(ba_new, word_shift_reg);
                    current_count_next   = 18'd0;
                end
                else if (req_chan.port[0])
                begin
                    base_count_next = {base_count_reg[idx][15:8], req_chan.write_data};
                end
                else
                begin
                    base_address_next = {base_address_reg[idx][15:8], req_chan.write_data};
                end
            end
            ACT_CTL_RD:
            begin
                if (req_chan.port == CTL_RD_STATUS)
                begin
                    read_data_next = status_reg;
                    status_next    = {status_reg[7:4], 4'h0};
                end
                else if (req_chan.port == CTL_RD_MASK)
                begin
                    read_data_next = mask_reg;
                end
            end
            ACT_CTL_WR:
            begin
                case (req_chan.port)
                    CTL_COMMAND:
                    begin
                        if (|(req_chan.write_data & CMD_UNSUPPORTED))
                        begin
                            rejected_next = 1'b1;
                        end
                        else
                        begin
                            command_next = req_chan.write_data;
                        end
                    end
                    CTL_REQUEST:
                    begin
                        status_next[{1'b1, idx}] = req_chan.write_data[2];
                        status_next[{1'b0, idx}] = 1'b0;
                    end
                    CTL_SINGLE_MASK: mask_next[{1'b0, idx}] = req_chan.write_data[2];
                    CTL_MODE:        channel_mode_next = req_chan.write_data;
                    CTL_CLEAR_FF:    byte_ff_next = 1'b0;
                    CTL_MASTER_RST:
                    begin
                        byte_ff_next = 1'b0;
                        mask_next    = 8'hff;
                        status_next  = 8'h00;
                        command_next = 8'h00;
                    end
                    CTL_MASK_CLEAR:  mask_next = 8'h00;
                    default:         mask_next = req_chan.write_data;
                endcase
            end
            ACT_PAGE_RD:  if (pmap.hit) read_data_next = page_low_reg[idx];
            ACT_PAGE_WR:  if (pmap.hit) page_low_next  = req_chan.write_data;
            ACT_HPAGE_RD: if (pmap.hit) read_data_next = page_high_reg[idx];
            ACT_HPAGE_WR: if (pmap.hit) page_high_next = req_chan.write_data;
            ACT_DREQ_HOLD: status_next[{1'b1, idx}] = 1'b1;
            ACT_DREQ_REL:  status_next[{1'b1, idx}] = 1'b0;
            ACT_PROGRESS:
            begin
                // Only an unmasked channel with DREQ pending advances
                if (!mask_reg[{1'b0, idx}] && status_reg[{1'b1, idx}])
                begin
                    current_count_next = req_chan.position;
                    if (req_chan.position == full_len)
                    begin
                        status_next[{1'b0, idx}] = 1'b1;
                    end
                end
            end
            ACT_ADDR_QUERY:
            begin
                verify_next   = (mode_sel[3:2] == 2'b00);
                autoinit_next = mode_sel[MODE_AUTOINIT_BIT];
                tlen_next     = full_len;
                if (mode_sel[3:2] != 2'b00)
                begin
                    if (mode_sel[MODE_DOWN_BIT])
                    begin
                        mem_address_next = phys - {14'd0, req_chan.position}
                                                - {14'd0, req_chan.length};
                    end
                    else
                    begin
                        mem_address_next = phys + {14'd0, req_chan.position};
                    end
                end
            end
            default: ;
        endcase
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_shift_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            word_shift_reg <= cfg_write_data;
        end
    end

    // Commit the register file on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                base_address_reg[i]    <= '0;
                base_count_reg[i]      <= '0;
                current_address_reg[i] <= '0;
                current_count_reg[i]   <= '0;
                channel_mode_reg[i]    <= '0;
                page_low_reg[i]        <= '0;
                page_high_reg[i]       <= '0;
            end
            command_reg <= 8'h00;
            mask_reg    <= 8'hff;
            status_reg  <= 8'h00;
            byte_ff_reg <= 1'b0;
        end
        else if (accept)
        begin
            base_address_reg[idx]    <= base_address_next;
            base_count_reg[idx]      <= base_count_next;
            current_address_reg[idx] <= current_address_next;
            current_count_reg[idx]   <= current_count_next;
            channel_mode_reg[idx]    <= channel_mode_next;
            page_low_reg[idx]        <= page_low_next;
            page_high_reg[idx]       <= page_high_next;
            command_reg              <= command_next;
            mask_reg                 <= mask_next;
            status_reg               <= status_next;
            byte_ff_reg              <= byte_ff_next;
        end
    end

    // Result valid: load on accept, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_chan.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg   <= read_data_next;
            active_reg      <= ~mask_next[3:0] & status_next[7:4];
            tc_reg          <= status_next[3:0];
            rejected_reg    <= rejected_next;
            mem_address_reg <= mem_address_next;
            verify_reg      <= verify_next;
            autoinit_reg    <= autoinit_next;
            tlen_reg        <= tlen_next;
        end
    end

    assign rsp_chan.valid            = out_valid_reg;
    assign rsp_chan.read_data        = read_data_reg;
    assign rsp_chan.active_channels  = active_reg;
    assign rsp_chan.terminal_count   = tc_reg;
    assign rsp_chan.command_rejected = rejected_reg;
    assign rsp_chan.mem_address      = mem_address_reg;
    assign rsp_chan.verify_only      = verify_reg;
    assign rsp_chan.autoinit         = autoinit_reg;
    assign rsp_chan.transfer_length  = tlen_reg;

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Testbench for the four-channel ISA DMA controller register block: directed table, then
// biased random requests under random stalls, checked against an in-bench register predictor.
// Depends on isadma_pkg, isadma_in_if, isadma_out_if and isa_dma_controller_registers_core.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import isadma_pkg::*;

    localparam int          HOLD_CYCLES  = 80;
    localparam int          STALL_LIMIT  = 1000;
    localparam int          MAX_REPORTS  = 10;
    localparam int          PHASE_ITEMS  = 150;
    localparam logic [3:0]  ACT_UNUSED_LO = 4'd12;
    localparam logic [3:0]  ACT_UNUSED_HI = 4'd15;
    localparam logic [7:0]  MODE_VERIFY_MASK = 8'h0c;

    typedef struct packed {
        logic [3:0]  action;
        logic [2:0]  port;
        logic [7:0]  write_data;
        logic [1:0]  channel;
        logic [17:0] position;
        logic [17:0] length;
    } request_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [3:0]  active_channels;
        logic [3:0]  terminal_count;
        logic        command_rejected;
        logic [31:0] mem_address;
        logic        verify_only;
        logic        autoinit;
        logic [17:0] transfer_length;
    } result_t;

    // Per-request note: a typed-in result replaces the predicted one
    typedef struct packed {
        logic    typed;
        result_t res;
    } note_t;

    typedef struct packed {
        request_t req;
        note_t    note;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write_en;
    logic cfg_write_data;

    isadma_in_if  req_if ();
    isadma_out_if rsp_if ();

    isa_dma_controller_registers_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .req_chan       (req_if),
        .rsp_chan       (rsp_if)
    );

    always #6 clk = ~clk;

    // Predicted register file
    logic [15:0] m_base_addr [CHANNEL_COUNT];
    logic [15:0] m_base_cnt  [CHANNEL_COUNT];
    logic [16:0] m_cur_addr  [CHANNEL_COUNT];
    logic [17:0] m_cur_cnt   [CHANNEL_COUNT];
    logic [7:0]  m_mode      [CHANNEL_COUNT];
    logic [7:0]  m_page_lo   [CHANNEL_COUNT];
    logic [7:0]  m_page_hi   [CHANNEL_COUNT];
    logic [7:0]  m_command;
    logic [7:0]  m_mask;
    logic [7:0]  m_status;
    logic        m_flip;
    logic        m_shift;

    result_t  expected_results [$];
    note_t    request_notes [$];
    dir_row_t directed_rows [$];
    int       fail_count = 0;
    bit       idle_on = 1'b1;
    bit       hold_req = 1'b0;

    // Full block length of a channel in bytes
    function automatic logic [17:0] block_span(input logic [1:0] ch);
        return (18'(m_base_cnt[ch]) + 18'd1) << m_shift;
    endfunction

    // Apply one request to the predicted registers and return its result
    function automatic result_t dma_regs_step(input request_t r);
        result_t     o;
        logic [1:0]  ch;
        logic [1:0]  dch;
        logic        hi;
        logic        page_hit;
        logic [1:0]  page_ch;
        logic [31:0] v;
        logic [31:0] phys;
        o = '0;
        ch = r.port[2:1];
        dch = r.write_data[1:0];
        page_hit = 1'b1;
        page_ch = 2'd0;
        case (r.port)
            3'd1:    page_ch = 2'd2;
            3'd2:    page_ch = 2'd3;
            3'd3:    page_ch = 2'd1;
            3'd7:    page_ch = 2'd0;
            default: page_hit = 1'b0;
        endcase
        case (r.action)
            ACT_CHAN_RD:
            begin
                hi = m_flip;
                m_flip = ~m_flip;
                if (r.port[0])
                    v = ({16'd0, m_base_cnt[ch]} << m_shift) - {14'd0, m_cur_cnt[ch]};
                else if (m_mode[ch][MODE_DOWN_BIT])
                    v = {15'd0, m_cur_addr[ch]} - {14'd0, m_cur_cnt[ch]};
                else
                    v = {15'd0, m_cur_addr[ch]} + {14'd0, m_cur_cnt[ch]};
                v = v >> m_shift;
                o.read_data = hi ? v[15:8] : v[7:0];
            end
            ACT_CHAN_WR:
            begin
                hi = m_flip;
                m_flip = ~m_flip;
                if (r.port[0] && hi)
                    m_base_cnt[ch][15:8] = r.write_data;
                else if (r.port[0])
                    m_base_cnt[ch][7:0] = r.write_data;
                else if (hi)
                    m_base_addr[ch][15:8] = r.write_data;
                else
                    m_base_addr[ch][7:0] = r.write_data;
                // High byte reloads the current address and clears the count
                if (hi)
                begin
                    m_cur_addr[ch] = m_shift ? {m_base_addr[ch], 1'b0} : {1'b0, m_base_addr[ch]};
                    m_cur_cnt[ch] = '0;
                end
            end
            ACT_CTL_RD:
            begin
                if (r.port == CTL_RD_STATUS)
                begin
                    o.read_data = m_status;
                    m_status[3:0] = 4'd0;
                end
                else if (r.port == CTL_RD_MASK)
                    o.read_data = m_mask;
            end
            ACT_CTL_WR:
            begin
                case (r.port)
                    CTL_COMMAND:
                        if (r.write_data != 8'd0 && (r.write_data & CMD_UNSUPPORTED) != 8'd0)
                            o.command_rejected = 1'b1;
                        else
                            m_command = r.write_data;
                    CTL_REQUEST:
                    begin
                        m_status[4 + dch] = r.write_data[2];
                        m_status[dch] = 1'b0;
                    end
                    CTL_SINGLE_MASK: m_mask[dch] = r.write_data[2];
                    CTL_MODE:        m_mode[dch] = r.write_data;
                    CTL_CLEAR_FF:    m_flip = 1'b0;
                    CTL_MASTER_RST:
                    begin
                        m_flip = 1'b0;
                        m_mask = 8'hff;
                        m_status = 8'h00;
                        m_command = 8'h00;
                    end
                    CTL_MASK_CLEAR:  m_mask = 8'h00;
                    default:         m_mask = r.write_data;
                endcase
            end
            ACT_PAGE_RD:  if (page_hit) o.read_data = m_page_lo[page_ch];
            ACT_PAGE_WR:  if (page_hit) m_page_lo[page_ch] = r.write_data;
            ACT_HPAGE_RD: if (page_hit) o.read_data = m_page_hi[page_ch];
            ACT_HPAGE_WR: if (page_hit) m_page_hi[page_ch] = r.write_data;
            ACT_DREQ_HOLD: m_status[4 + r.channel] = 1'b1;
            ACT_DREQ_REL:  m_status[4 + r.channel] = 1'b0;
            ACT_PROGRESS:
            begin
                // Only an unmasked channel with DREQ pending moves
                if (!m_mask[r.channel] && m_status[4 + r.channel])
                begin
                    m_cur_cnt[r.channel] = r.position;
                    if (r.position == block_span(r.channel))
                        m_status[r.channel] = 1'b1;
                end
            end
            ACT_ADDR_QUERY:
            begin
                phys = {1'b0, m_page_hi[r.channel][6:0], 24'd0}
                     | {8'd0, m_page_lo[r.channel], 16'd0}
                     | {15'd0, m_cur_addr[r.channel]};
                o.verify_only = (m_mode[r.channel] & MODE_VERIFY_MASK) == 8'd0;
                o.autoinit = m_mode[r.channel][MODE_AUTOINIT_BIT];
                o.transfer_length = block_span(r.channel);
                if (!o.verify_only && m_mode[r.channel][MODE_DOWN_BIT])
                    o.mem_address = phys - {14'd0, r.position} - {14'd0, r.length};
                else if (!o.verify_only)
                    o.mem_address = phys + {14'd0, r.position};
            end
            default: ;
        endcase
        o.active_channels = ~m_mask[3:0] & m_status[7:4];
        o.terminal_count = m_status[3:0];
        return o;
    endfunction

    function automatic string fmt_result(input result_t x);
        return $sformatf("rd=%02h act=%h tc=%h rej=%b addr=%08h ver=%b ai=%b len=%05h",
                         x.read_data, x.active_channels, x.terminal_count,
                         x.command_rejected, x.mem_address, x.verify_only,
                         x.autoinit, x.transfer_length);
    endfunction

    function automatic dir_row_t row(input logic [3:0] act, input logic [2:0] port,
                                     input logic [7:0] data, input logic [1:0] ch,
                                     input logic [17:0] pos, input logic [17:0] len);
        dir_row_t d;
        d = '0;
        d.req = '{act, port, data, ch, pos, len};
        return d;
    endfunction

    function automatic dir_row_t typed_row(input logic [3:0] act, input logic [2:0] port,
                                           input logic [7:0] data, input logic [7:0] rd,
                                           input logic rej);
        dir_row_t d;
        d = row(act, port, data, 2'd0, 18'd0, 18'd0);
        d.note.typed = 1'b1;
        d.note.res.read_data = rd;
        d.note.res.command_rejected = rej;
        return d;
    endfunction

    // Draw one request, biased toward sequences that reach transfers and queries
    function automatic request_t draw_request();
        request_t r;
        int       pick;
        r.action = ACT_CHAN_WR;
        r.port = 3'($urandom_range(7));
        r.write_data = 8'($urandom_range(255));
        r.channel = 2'($urandom_range(3));
        r.position = 18'($urandom);
        r.length = 18'($urandom);
        pick = $urandom_range(99);
        if (pick < 14)
            r.action = ACT_CHAN_WR;
        else if (pick < 24)
            r.action = ACT_CHAN_RD;
        else if (pick < 34)
        begin
            r.action = ACT_CTL_WR;
            if (r.port == CTL_MASTER_RST && $urandom_range(3) != 0)
                r.port = CTL_SINGLE_MASK;
            if (r.port == CTL_COMMAND && $urandom_range(1) == 0)
                r.write_data = r.write_data & ~CMD_UNSUPPORTED;
            if (r.port == CTL_SINGLE_MASK && $urandom_range(1) == 0)
                r.write_data[2] = 1'b0;
        end
        else if (pick < 42)
        begin
            r.action = ACT_CTL_RD;
            if ($urandom_range(3) != 0)
                r.port = 3'($urandom_range(1));
        end
        else if (pick < 50)
            r.action = 4'(ACT_PAGE_RD) + 4'($urandom_range(3));
        else if (pick < 58)
            r.action = ACT_DREQ_HOLD;
        else if (pick < 62)
            r.action = ACT_DREQ_REL;
        else if (pick < 77)
        begin
            r.action = ACT_PROGRESS;
            if ($urandom_range(1) == 0)
                r.position = block_span(r.channel);
            else if ($urandom_range(1) == 0)
                r.position = 18'($urandom_range(255));
        end
        else if (pick < 92)
        begin
            r.action = ACT_ADDR_QUERY;
            if ($urandom_range(1) == 0)
            begin
                r.position = 18'($urandom_range(255));
                r.length = 18'($urandom_range(255));
            end
        end
        else if (pick < 97)
        begin
            r.action = ACT_CTL_WR;
            r.port = CTL_MASK_CLEAR;
        end
        else
            r.action = 4'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
        return r;
    endfunction

    // Offer one request at the falling edge and hold it until accepted
    task automatic offer_request(input request_t r, input note_t n);
        int gap;
        gap = (idle_on && $urandom_range(99) < 30) ? $urandom_range(4, 1) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        request_notes.push_back(n);
        req_if.valid      <= 1'b1;
        req_if.action     <= r.action;
        req_if.port       <= r.port;
        req_if.write_data <= r.write_data;
        req_if.channel    <= r.channel;
        req_if.position   <= r.position;
        req_if.length     <= r.length;
        do
            @(posedge clk);
        while (!req_if.ready);
    endtask

    // Drop valid and wait until every expected result is back
    task automatic drain_results();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_word_shift(input logic v);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        m_shift = v;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // Check results and record accepted requests at each rising edge
    always @(posedge clk)
    begin : monitor
        result_t  got;
        result_t  want;
        request_t r;
        note_t    n;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.read_data        = rsp_if.read_data;
            got.active_channels  = rsp_if.active_channels;
            got.terminal_count   = rsp_if.terminal_count;
            got.command_rejected = rsp_if.command_rejected;
            got.mem_address      = rsp_if.mem_address;
            got.verify_only      = rsp_if.verify_only;
            got.autoinit         = rsp_if.autoinit;
            got.transfer_length  = rsp_if.transfer_length;
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: %s", fmt_result(got));
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.read_data !== want.read_data
                    || got.active_channels !== want.active_channels
                    || got.terminal_count !== want.terminal_count
                    || got.command_rejected !== want.command_rejected
                    || got.mem_address !== want.mem_address
                    || got.verify_only !== want.verify_only
                    || got.autoinit !== want.autoinit
                    || got.transfer_length !== want.transfer_length)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch at %0t\n  expected %s\n  actual   %s",
                                 $realtime, fmt_result(want), fmt_result(got));
                end
            end
        end
        if (rst_n && req_if.valid && req_if.ready)
        begin
            r = '{req_if.action, req_if.port, req_if.write_data, req_if.channel,
                  req_if.position, req_if.length};
            want = dma_regs_step(r);
            n = (request_notes.size() != 0) ? request_notes.pop_front() : '0;
            expected_results.push_back(n.typed ? n.res : want);
        end
    end

    // Drive the result-side ready, with one long hold-off on request
    initial
    begin : result_sink
        int held;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                rsp_if.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            rsp_if.ready <= !(idle_on && $urandom_range(99) < 30);
        end
    end

    // End the run when nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        int phase;
        // Hold every input at a known value through reset
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = 1'b0;
        req_if.valid = 1'b0;
        req_if.action = ACT_CHAN_RD;
        req_if.port = '0;
        req_if.write_data = '0;
        req_if.channel = '0;
        req_if.position = '0;
        req_if.length = '0;
        for (i = 0; i < CHANNEL_COUNT; i++)
        begin
            m_base_addr[i] = '0;
            m_base_cnt[i] = '0;
            m_cur_addr[i] = '0;
            m_cur_cnt[i] = '0;
            m_mode[i] = '0;
            m_page_lo[i] = '0;
            m_page_hi[i] = '0;
        end
        m_command = 8'h00;
        m_mask = 8'hff;
        m_status = 8'h00;
        m_flip = 1'b0;
        m_shift = 1'b0;

        // Directed rows: reset values, rejected command, unmapped page, then a full transfer
        directed_rows.push_back(typed_row(ACT_CTL_RD, CTL_RD_MASK, 8'h00, 8'hff, 1'b0));
        directed_rows.push_back(typed_row(ACT_CTL_WR, CTL_COMMAND, 8'hff, 8'h00, 1'b1));
        directed_rows.push_back(typed_row(ACT_CTL_WR, CTL_COMMAND, 8'h04, 8'h00, 1'b0));
        directed_rows.push_back(typed_row(ACT_CHAN_RD, 3'd7, 8'h00, 8'h00, 1'b0));
        directed_rows.push_back(typed_row(ACT_CTL_WR, CTL_CLEAR_FF, 8'h00, 8'h00, 1'b0));
        directed_rows.push_back(typed_row(ACT_PAGE_WR, 3'd0, 8'haa, 8'h00, 1'b0));
        directed_rows.push_back(typed_row(ACT_PAGE_RD, 3'd0, 8'h00, 8'h00, 1'b0));
        directed_rows.push_back(row(ACT_CHAN_WR, 3'd0, 8'h34, 2'd0, 18'd0, 18'd0));
        directed_rows.push_back(row(ACT_CHAN_WR, 3'd0, 8'h12, 2'd0, 18'd0, 18'd0));
        directed_rows.push_back(row(ACT_CHAN_WR, 3'd1, 8'hff, 2'd0, 18'd0, 18'd0));
        directed_rows.push_back(row(ACT_CHAN_WR, 3'd1, 8'hff, 2'd0, 18'd0, 18'd0));
        directed_rows.push_back(row(ACT_CTL_WR, CTL_MODE, 8'h58, 2'd0, 18'd0, 18'd0));
        directed_rows.push_back(row(ACT_PAGE_WR, 3'd7, 8'hff, 2'd0, 18'd0, 18'd0));
        directed_rows.push_back(row(ACT_HPAGE_WR, 3'd7, 8'hff, 2'd0, 18'd0, 18'd0));
        directed_rows.push_back(row(ACT_DREQ_HOLD, 3'd0, 8'h00, 2'd0, 18'd0, 18'd0));
        directed_rows.push_back(row(ACT_PROGRESS, 3'd0, 8'h00, 2'd0, 18'd5, 18'd0));
        directed_rows.push_back(row(ACT_CTL_WR, CTL_SINGLE_MASK, 8'h00, 2'd0, 18'd0, 18'd0));
        directed_rows.push_back(row(ACT_PROGRESS, 3'd0, 8'h00, 2'd0, 18'h10000, 18'd0));
        directed_rows.push_back(row(ACT_ADDR_QUERY, 3'd0, 8'h00, 2'd0, 18'h3ffff, 18'h3ffff));
        directed_rows.push_back(row(ACT_CTL_WR, CTL_MODE, 8'h21, 2'd0, 18'd0, 18'd0));
        directed_rows.push_back(row(ACT_ADDR_QUERY, 3'd0, 8'h00, 2'd1, 18'd7, 18'd9));
        directed_rows.push_back(row(ACT_CHAN_RD, 3'd0, 8'h00, 2'd0, 18'd0, 18'd0));
        directed_rows.push_back(row(ACT_CTL_RD, CTL_RD_STATUS, 8'h00, 2'd0, 18'd0, 18'd0));
        directed_rows.push_back(row(ACT_DREQ_REL, 3'd0, 8'h00, 2'd0, 18'd0, 18'd0));
        directed_rows.push_back(row(ACT_CTL_WR, CTL_MASTER_RST, 8'h00, 2'd0, 18'd0, 18'd0));
        directed_rows.push_back(row(ACT_UNUSED_HI, 3'd7, 8'hff, 2'd3, 18'h3ffff, 18'h3ffff));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
            offer_request(directed_rows[k].req, directed_rows[k].note);

        // Random phases alternate the word shift; phase 1 runs without idling
        for (phase = 0; phase < 4; phase++)
        begin
            drain_results();
            write_word_shift(phase % 2 == 0);
            idle_on = (phase != 1);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 0 && i == 20)
                    hold_req = 1'b1;
                if (phase == 2 && i == 75)
                    drain_results();
                offer_request(draw_request(), '0);
            end
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
